### design/tgi_pkg.sv
// ----------------------------------------------------------------------------
// tgi_pkg: shared types and constants of the touch gesture inertia unit
// Field widths, result kinds, register indexes and their reset values.
// ----------------------------------------------------------------------------
package tgi_pkg;

  // input modes
  localparam logic MODE_TOUCH = 1'b0;
  localparam logic MODE_TICK  = 1'b1;

  // result kinds
  localparam logic [2:0] KIND_TAP         = 3'd0;
  localparam logic [2:0] KIND_SCROLL_DOWN = 3'd1;
  localparam logic [2:0] KIND_SCROLL_UP   = 3'd2;
  localparam logic [2:0] KIND_SWIPE_RIGHT = 3'd3;
  localparam logic [2:0] KIND_SWIPE_LEFT  = 3'd4;

  // configuration register indexes
  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 32;
  localparam logic [CFG_INDEX_W-1:0] REG_SCROLL_THRESHOLD = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SWIPE_THRESHOLD  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_MIN_SPEED        = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_SPEED        = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_DECAY_STEP       = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_TAP_LIMIT        = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_SCROLL_INTERVAL  = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_SWIPE_INTERVAL   = 3'd7;

  // register reset values
  localparam logic [14:0]        RST_SCROLL_THRESHOLD = 15'd491;
  localparam logic [14:0]        RST_SWIPE_THRESHOLD  = 15'd491;
  localparam logic [14:0]        RST_MIN_SPEED        = 15'd16;
  localparam logic [14:0]        RST_MAX_SPEED        = 15'd491;
  localparam logic [14:0]        RST_DECAY_STEP       = 15'd25;
  localparam logic [15:0]        RST_TAP_LIMIT        = 16'd80;
  localparam logic signed [31:0] RST_INTERVAL         = -32'sd1;

  // configuration registers
  typedef struct packed {
    logic [14:0]        scroll_threshold;
    logic [14:0]        swipe_threshold;
    logic [14:0]        min_speed;
    logic [14:0]        max_speed;
    logic [14:0]        decay_step;
    logic [15:0]        tap_limit;
    logic signed [31:0] scroll_interval;
    logic signed [31:0] swipe_interval;
  } cfg_t;

  // one input item
  typedef struct packed {
    logic               mode;
    logic               released;
    logic [15:0]        moved_distance;
    logic [15:0]        pos_x;
    logic [15:0]        pos_y;
    logic signed [15:0] delta_x;
    logic signed [15:0] delta_y;
    logic [31:0]        stamp;
  } item_t;

  // one result item
  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] tap_x;
    logic [15:0] tap_y;
    logic [15:0] speed;
    logic        last;
  } result_t;

endpackage

### design/tgi_touch_if.sv
// ----------------------------------------------------------------------------
// tgi_touch_if: input channel of the touch gesture inertia unit
// Carries touch events and frame ticks with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface tgi_touch_if;
  logic               valid;
  logic               ready;
  logic               mode;
  logic               released;
  logic [15:0]        moved_distance;
  logic [15:0]        pos_x;
  logic [15:0]        pos_y;
  logic signed [15:0] delta_x;
  logic signed [15:0] delta_y;
  logic [31:0]        stamp;

  modport source (
    output valid, mode, released, moved_distance, pos_x, pos_y,
           delta_x, delta_y, stamp,
    input  ready
  );

  modport sink (
    input  valid, mode, released, moved_distance, pos_x, pos_y,
           delta_x, delta_y, stamp,
    output ready
  );
endinterface

### design/tgi_result_if.sv
// ----------------------------------------------------------------------------
// tgi_result_if: result channel of the touch gesture inertia unit
// Carries gesture results with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface tgi_result_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [15:0] tap_x;
  logic [15:0] tap_y;
  logic [15:0] speed;
  logic        last;

  modport source (
    output valid, kind, tap_x, tap_y, speed, last,
    input  ready
  );

  modport sink (
    input  valid, kind, tap_x, tap_y, speed, last,
    output ready
  );
endinterface

### design/tgi_engine.sv
// ----------------------------------------------------------------------------
// tgi_engine: gesture classification and inertial speed state
// Works out the results of one item and updates speeds and stamps on fire.
// ----------------------------------------------------------------------------
module tgi_engine (
  input  logic             clk,
  input  logic             rst,
  input  logic             fire,
  input  tgi_pkg::item_t   item,
  input  tgi_pkg::cfg_t    cfg,
  output logic [1:0]       res_count,
  output tgi_pkg::result_t res0,
  output tgi_pkg::result_t res1
);
  import tgi_pkg::*;

  typedef struct packed {
    logic               emit;
    logic               neg;
    logic [15:0]        mag;
    logic signed [17:0] next;
  } rel_t;

  logic signed [17:0] scroll_speed;
  logic signed [17:0] swipe_speed;
  logic [31:0]        scroll_now;
  logic [31:0]        scroll_done;
  logic [31:0]        swipe_now;
  logic [31:0]        swipe_done;

  logic               scroll_due;
  logic               swipe_due;
  logic [31:0]        scroll_gap;
  logic [31:0]        swipe_gap;
  rel_t               scroll_rel;
  rel_t               swipe_rel;
  logic [16:0]        abs_x;
  logic [16:0]        abs_y;
  logic               counted;
  logic               vertical;
  logic signed [17:0] scroll_acc;
  logic signed [17:0] swipe_acc;
  result_t            scroll_res;
  result_t            swipe_res;

  // add a delta to a speed, clamp beyond the dead band
  function automatic logic signed [17:0] accumulate(
    input logic signed [17:0] spd,
    input logic signed [15:0] delta,
    input logic [14:0]        lo_v,
    input logic [14:0]        hi_v
  );
    logic signed [17:0] sum;
    logic signed [17:0] lo;
    logic signed [17:0] hi;
    logic signed [17:0] res;
    sum = spd + $signed({{2{delta[15]}}, delta});
    lo  = $signed({3'b000, lo_v});
    hi  = $signed({3'b000, hi_v});
    res = sum;
    if (sum > lo) begin
      if (sum > hi) res = hi;
    end else if (sum < -lo) begin
      if (sum < -hi) res = -hi;
    end
    return res;
  endfunction

  // emit a speed outside the dead band and decay it toward zero
  function automatic rel_t release_axis(
    input logic signed [17:0] spd,
    input logic [14:0]        lo_v,
    input logic [14:0]        dec_v
  );
    logic signed [17:0] lo;
    logic signed [17:0] dec;
    logic signed [17:0] neg_spd;
    logic signed [17:0] step;
    rel_t               r;
    lo      = $signed({3'b000, lo_v});
    dec     = $signed({3'b000, dec_v});
    neg_spd = -spd;
    r       = '0;
    if (spd > lo) begin
      step   = spd - dec;
      r.emit = 1'b1;
      r.mag  = spd[15:0];
      r.next = (step < 0) ? 18'sd0 : step;
    end else if (spd < -lo) begin
      step   = spd + dec;
      r.emit = 1'b1;
      r.neg  = 1'b1;
      r.mag  = neg_spd[15:0];
      r.next = (step > 0) ? 18'sd0 : step;
    end
    return r;
  endfunction

  // release test on wrapping stamp difference
  assign scroll_gap = scroll_now - scroll_done;
  assign swipe_gap  = swipe_now - swipe_done;
  assign scroll_due = cfg.scroll_interval[31] || ($signed(scroll_gap) > cfg.scroll_interval);
  assign swipe_due  = cfg.swipe_interval[31] || ($signed(swipe_gap) > cfg.swipe_interval);

  assign scroll_rel = release_axis(scroll_speed, cfg.min_speed, cfg.decay_step);
  assign swipe_rel  = release_axis(swipe_speed, cfg.min_speed, cfg.decay_step);

  // movement: magnitudes, threshold test and axis choice
  assign abs_x    = item.delta_x[15] ? 17'(-{item.delta_x[15], item.delta_x})
                                     : {1'b0, item.delta_x};
  assign abs_y    = item.delta_y[15] ? 17'(-{item.delta_y[15], item.delta_y})
                                     : {1'b0, item.delta_y};
  assign counted  = !(abs_y < {2'b00, cfg.scroll_threshold} &&
                      abs_x < {2'b00, cfg.swipe_threshold});
  assign vertical = abs_y > abs_x;

  assign scroll_acc = accumulate(scroll_speed, item.delta_y, cfg.min_speed, cfg.max_speed);
  assign swipe_acc  = accumulate(swipe_speed, item.delta_x, cfg.min_speed, cfg.max_speed);

  // result words of the two axes
  always_comb begin
    scroll_res       = '0;
    scroll_res.kind  = scroll_rel.neg ? KIND_SCROLL_UP : KIND_SCROLL_DOWN;
    scroll_res.speed = scroll_rel.mag;
    swipe_res        = '0;
    swipe_res.kind   = swipe_rel.neg ? KIND_SWIPE_LEFT : KIND_SWIPE_RIGHT;
    swipe_res.speed  = swipe_rel.mag;
    swipe_res.last   = 1'b1;
  end

  // results of the item
  always_comb begin
    res_count = 2'd0;
    res0      = '0;
    res1      = swipe_res;
    if (item.mode == MODE_TICK) begin
      if (scroll_due && scroll_rel.emit) begin
        res0      = scroll_res;
        res0.last = !(swipe_due && swipe_rel.emit);
        res_count = (swipe_due && swipe_rel.emit) ? 2'd2 : 2'd1;
      end else if (swipe_due && swipe_rel.emit) begin
        res0      = swipe_res;
        res_count = 2'd1;
      end
    end else if (item.released) begin
      if (item.moved_distance < cfg.tap_limit) begin
        res0.kind  = KIND_TAP;
        res0.tap_x = item.pos_x;
        res0.tap_y = item.pos_y;
        res0.last  = 1'b1;
        res_count  = 2'd1;
      end
    end
  end

  // speed and stamp state
  always_ff @(posedge clk) begin
    if (rst) begin
      scroll_speed <= '0;
      swipe_speed  <= '0;
      scroll_now   <= '0;
      scroll_done  <= '0;
      swipe_now    <= '0;
      swipe_done   <= '0;
    end else if (fire) begin
      if (item.mode == MODE_TICK) begin
        if (scroll_due) begin
          scroll_done  <= scroll_now;
          scroll_speed <= scroll_rel.next;
        end
        if (swipe_due) begin
          swipe_done  <= swipe_now;
          swipe_speed <= swipe_rel.next;
        end
      end else if (!item.released && counted) begin
        if (vertical) begin
          scroll_now   <= item.stamp;
          scroll_speed <= scroll_acc;
        end else begin
          swipe_now   <= item.stamp;
          swipe_speed <= swipe_acc;
        end
      end
    end
  end

`ifndef ASSERT_OFF
  a_scroll_bound: assert property (@(posedge clk) disable iff (rst)
    scroll_speed <= 18'sd32767 && scroll_speed >= -18'sd32767)
    else $error("scroll speed out of range");

  a_swipe_bound: assert property (@(posedge clk) disable iff (rst)
    swipe_speed <= 18'sd32767 && swipe_speed >= -18'sd32767)
    else $error("swipe speed out of range");

  a_scroll_always_due: assert property (@(posedge clk) disable iff (rst)
    fire && item.mode == MODE_TICK && cfg.scroll_interval[31]
    |=> scroll_done == $past(scroll_now))
    else $error("scroll release did not record its stamp");
`endif

endmodule

### design/tgi_result_buf.sv
// ----------------------------------------------------------------------------
// tgi_result_buf: two-slot result register for the output channel
// Holds the results of one item and shifts them out one transfer at a time.
// ----------------------------------------------------------------------------
module tgi_result_buf (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  logic [1:0]       load_count,
  input  tgi_pkg::result_t res0,
  input  tgi_pkg::result_t res1,
  output logic             can_load,
  tgi_result_if.source     result
);
  import tgi_pkg::*;

  logic [1:0] count;
  result_t    slot0;
  result_t    slot1;
  logic       pop;
  logic       push;

  assign pop      = (count != 2'd0) && result.ready;
  assign can_load = (count == 2'd0) || (count == 2'd1 && pop);
  assign push     = load && (load_count != 2'd0);

  // occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else if (push) begin
      count <= load_count;
    end else if (pop) begin
      count <= count - 2'd1;
    end
  end

  // slot data
  always_ff @(posedge clk) begin
    if (push) begin
      slot0 <= res0;
      slot1 <= res1;
    end else if (pop && count == 2'd2) begin
      slot0 <= slot1;
    end
  end

  // head slot drives the channel
  assign result.valid = (count != 2'd0);
  assign result.kind  = slot0.kind;
  assign result.tap_x = slot0.tap_x;
  assign result.tap_y = slot0.tap_y;
  assign result.speed = slot0.speed;
  assign result.last  = slot0.last;

`ifndef ASSERT_OFF
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3)
    else $error("result buffer overfilled");

  a_single_last: assert property (@(posedge clk) disable iff (rst)
    count == 2'd1 |-> slot0.last)
    else $error("lone result is not marked last");

  a_pair_last: assert property (@(posedge clk) disable iff (rst)
    count == 2'd2 |-> (!slot0.last && slot1.last))
    else $error("result pair has wrong last marks");
`endif

endmodule

### design/touch_gesture_inertia_unit.sv
// ----------------------------------------------------------------------------
// touch_gesture_inertia_unit: touch gesture classifier with inertial speeds
// Taps, scroll and swipe speed accumulation, rate-limited release and decay.
// ----------------------------------------------------------------------------
//  channel  dir  handshake      payload
//  touch    in   valid/ready    mode released moved_distance pos_x pos_y
//                               delta_x delta_y stamp
//  result   out  valid/ready    kind tap_x tap_y speed last
//  cfg      in   cfg_write      cfg_index cfg_data (no read-back)
//
// An accepted item is held in the input register and its results are loaded
// into the result buffer when it fires; a new item is taken every cycle while
// the register is empty or firing. A frame tick with two results fills the
// two-slot result buffer, so a following item with results waits in the input
// register. Items without results pass even while the result buffer is full.
// Synchronous reset clears speeds, stamps, valids and loads register defaults.
// ----------------------------------------------------------------------------
module touch_gesture_inertia_unit (
  input  logic                                clk,
  input  logic                                rst,
  tgi_touch_if.sink                           touch,
  tgi_result_if.source                        result,
  input  logic                                cfg_write,
  input  logic [tgi_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [tgi_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import tgi_pkg::*;

  cfg_t       cfg;
  item_t      item_q;
  logic       held;
  logic       fire;
  logic       accept;
  logic       can_load;
  logic [1:0] res_count;
  result_t    res0;
  result_t    res1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.scroll_threshold <= RST_SCROLL_THRESHOLD;
      cfg.swipe_threshold  <= RST_SWIPE_THRESHOLD;
      cfg.min_speed        <= RST_MIN_SPEED;
      cfg.max_speed        <= RST_MAX_SPEED;
      cfg.decay_step       <= RST_DECAY_STEP;
      cfg.tap_limit        <= RST_TAP_LIMIT;
      cfg.scroll_interval  <= RST_INTERVAL;
      cfg.swipe_interval   <= RST_INTERVAL;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_SCROLL_THRESHOLD: cfg.scroll_threshold <= cfg_data[14:0];
        REG_SWIPE_THRESHOLD:  cfg.swipe_threshold  <= cfg_data[14:0];
        REG_MIN_SPEED:        cfg.min_speed        <= cfg_data[14:0];
        REG_MAX_SPEED:        cfg.max_speed        <= cfg_data[14:0];
        REG_DECAY_STEP:       cfg.decay_step       <= cfg_data[14:0];
        REG_TAP_LIMIT:        cfg.tap_limit        <= cfg_data[15:0];
        REG_SCROLL_INTERVAL:  cfg.scroll_interval  <= $signed(cfg_data);
        REG_SWIPE_INTERVAL:   cfg.swipe_interval   <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // input register handshake
  assign fire        = held && (can_load || res_count == 2'd0);
  assign touch.ready = !held || fire;
  assign accept      = touch.valid && touch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (accept) begin
      held <= 1'b1;
    end else if (fire) begin
      held <= 1'b0;
    end
  end

  // input payload capture
  always_ff @(posedge clk) begin
    if (accept) begin
      item_q.mode           <= touch.mode;
      item_q.released       <= touch.released;
      item_q.moved_distance <= touch.moved_distance;
      item_q.pos_x          <= touch.pos_x;
      item_q.pos_y          <= touch.pos_y;
      item_q.delta_x        <= touch.delta_x;
      item_q.delta_y        <= touch.delta_y;
      item_q.stamp          <= touch.stamp;
    end
  end

  // gesture logic and speed state
  tgi_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .item      (item_q),
    .cfg       (cfg),
    .res_count (res_count),
    .res0      (res0),
    .res1      (res1)
  );

  // result register toward the output channel
  tgi_result_buf u_result_buf (
    .clk        (clk),
    .rst        (rst),
    .load       (fire),
    .load_count (res_count),
    .res0       (res0),
    .res1       (res1),
    .can_load   (can_load),
    .result     (result)
  );

endmodule

### dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: touch gesture inertia unit
// Drives touch events and frame ticks through the input channel and checks
// every gesture result against a local model of taps, speed accumulation,
// rate-limited release and decay. A short table of directed items comes
// first, then random phases under several register settings and idle patterns.
// ----------------------------------------------------------------------------
module testbench;
  import tgi_pkg::*;

  typedef enum int {IDLE_NONE, IDLE_TX, IDLE_RX, IDLE_BOTH} idle_mode_t;

  typedef struct {
    item_t   item;
    bit      fixed_exp;
    int      n;
    result_t r0;
    result_t r1;
  } dir_row_t;

  localparam result_t NO_RESULT = '0;

  logic                   clk;
  logic                   rst;
  logic                   cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  tgi_touch_if  touch_ch ();
  tgi_result_if result_ch ();

  touch_gesture_inertia_unit dut (
    .clk       (clk),
    .rst       (rst),
    .touch     (touch_ch),
    .result    (result_ch),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // model state: registers, speeds and stamps
  cfg_t        model_cfg;
  int          scroll_spd;
  int          swipe_spd;
  logic [31:0] scroll_now;
  logic [31:0] scroll_done;
  logic [31:0] swipe_now;
  logic [31:0] swipe_done;

  result_t     expected_gestures[$];
  dir_row_t    dir_rows[$];
  int          mismatch_count = 0;
  int          tx_idle_pct = 0;
  int          rx_stall_pct = 0;
  int          hold_left = 0;
  logic [31:0] stamp_clock = '0;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("testbench: done, errors");
    $finish;
  end

  // ---------------------------------------------------------------- model

  // add a delta to a speed, clamp when outside the dead band
  function automatic int pull_speed(int spd, int d);
    int lo;
    int hi;
    lo = int'(model_cfg.min_speed);
    hi = int'(model_cfg.max_speed);
    spd += d;
    if (spd > lo) begin
      if (spd > hi) spd = hi;
    end else if (spd < -lo) begin
      if (spd < -hi) spd = -hi;
    end
    return spd;
  endfunction

  // release test with wrapping stamp difference
  function automatic bit is_due(logic [31:0] now, logic [31:0] done,
                                logic signed [31:0] interval);
    logic signed [31:0] diff;
    diff = now - done;
    if (interval < 0) return 1'b1;
    return diff > interval;
  endfunction

  // emit one axis speed if beyond the dead band, then decay toward zero
  function automatic bit release_axis(inout int spd, input logic [2:0] kpos,
                                      input logic [2:0] kneg, output result_t r);
    int lo;
    int dec;
    lo  = int'(model_cfg.min_speed);
    dec = int'(model_cfg.decay_step);
    r   = '0;
    if (spd > lo) begin
      r.kind  = kpos;
      r.speed = 16'(spd);
      spd -= dec;
      if (spd < 0) spd = 0;
      return 1'b1;
    end
    if (spd < -lo) begin
      r.kind  = kneg;
      r.speed = 16'(-spd);
      spd += dec;
      if (spd > 0) spd = 0;
      return 1'b1;
    end
    spd = 0;
    return 1'b0;
  endfunction

  function automatic void predict_gestures(input item_t it, output result_t res [2],
                                           output int n);
    result_t r;
    int      fx;
    int      fy;
    n = 0;
    res[0] = '0;
    res[1] = '0;
    if (it.mode == MODE_TICK) begin
      if (is_due(scroll_now, scroll_done, model_cfg.scroll_interval)) begin
        scroll_done = scroll_now;
        if (release_axis(scroll_spd, KIND_SCROLL_DOWN, KIND_SCROLL_UP, r)) begin
          res[n] = r;
          n++;
        end
      end
      if (is_due(swipe_now, swipe_done, model_cfg.swipe_interval)) begin
        swipe_done = swipe_now;
        if (release_axis(swipe_spd, KIND_SWIPE_RIGHT, KIND_SWIPE_LEFT, r)) begin
          res[n] = r;
          n++;
        end
      end
    end else if (it.released) begin
      if (it.moved_distance < model_cfg.tap_limit) begin
        res[0] = '0;
        res[0].kind  = KIND_TAP;
        res[0].tap_x = it.pos_x;
        res[0].tap_y = it.pos_y;
        n = 1;
      end
    end else begin
      fx = int'(it.delta_x);
      fy = int'(it.delta_y);
      if (fx < 0) fx = -fx;
      if (fy < 0) fy = -fy;
      if (!(fy < int'(model_cfg.scroll_threshold) &&
            fx < int'(model_cfg.swipe_threshold))) begin
        // vertical wins only when strictly larger
        if (fy > fx) begin
          scroll_now = it.stamp;
          scroll_spd = pull_speed(scroll_spd, int'(it.delta_y));
        end else begin
          swipe_now = it.stamp;
          swipe_spd = pull_speed(swipe_spd, int'(it.delta_x));
        end
      end
    end
    if (n > 0) res[n-1].last = 1'b1;
  endfunction

  // append one expected result at the tail
  function automatic void enqueue_result(input result_t r);
    expected_gestures.insert(expected_gestures.size(), r);
  endfunction

  task automatic queue_prediction(input item_t it);
    result_t res [2];
    int      n;
    predict_gestures(it, res, n);
    for (int i = 0; i < n; i++) enqueue_result(res[i]);
  endtask

  // ---------------------------------------------------------------- checking

  task automatic flag_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic check_result();
    result_t want;
    if (expected_gestures.size() == 0) begin
      flag_mismatch($sformatf("result kind %0d with none expected", result_ch.kind));
    end else begin
      want = expected_gestures.pop_front();
      if (result_ch.kind !== want.kind)
        flag_mismatch($sformatf("kind %0d, want %0d", result_ch.kind, want.kind));
      if (result_ch.tap_x !== want.tap_x)
        flag_mismatch($sformatf("tap_x %h, want %h", result_ch.tap_x, want.tap_x));
      if (result_ch.tap_y !== want.tap_y)
        flag_mismatch($sformatf("tap_y %h, want %h", result_ch.tap_y, want.tap_y));
      if (result_ch.speed !== want.speed)
        flag_mismatch($sformatf("speed %0d, want %0d", result_ch.speed, want.speed));
      if (result_ch.last !== want.last)
        flag_mismatch($sformatf("last %b, want %b", result_ch.last, want.last));
    end
  endtask

  // result side: check each transfer, stall at random or hold off on request
  initial begin
    result_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && result_ch.valid && result_ch.ready) check_result();
      if (hold_left > 0) begin
        result_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        result_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  // ---------------------------------------------------------------- stimulus

  function automatic item_t mk_item(logic mode, logic rel, logic [15:0] moved,
                                    logic [15:0] x, logic [15:0] y,
                                    logic signed [15:0] dx, logic signed [15:0] dy,
                                    logic [31:0] st);
    item_t it;
    it.mode           = mode;
    it.released       = rel;
    it.moved_distance = moved;
    it.pos_x          = x;
    it.pos_y          = y;
    it.delta_x        = dx;
    it.delta_y        = dy;
    it.stamp          = st;
    return it;
  endfunction

  function automatic void add_row(item_t it, bit fixed_exp, int n,
                                  result_t r0, result_t r1);
    dir_row_t row;
    row.item      = it;
    row.fixed_exp = fixed_exp;
    row.n         = n;
    row.r0        = r0;
    row.r1        = r1;
    dir_rows.insert(dir_rows.size(), row);
  endfunction

  // one random item; mostly counted moves, lifts near the tap limit and ticks
  function automatic item_t gen_item();
    item_t it;
    int    pick;
    int    thr;
    int    mag;
    int    other;
    int    dval;
    int    oval;
    int    travel;
    bit    vertical;
    it = mk_item(1'($urandom), 1'($urandom), 16'($urandom), 16'($urandom),
                 16'($urandom), 16'($urandom), 16'($urandom), $urandom);
    stamp_clock += $urandom_range(0, 8);
    if ($urandom_range(49) == 0) stamp_clock = $urandom;
    pick = $urandom_range(99);
    if (pick < 45) begin
      // move whose major axis lands around its threshold
      it.mode     = MODE_TOUCH;
      it.released = 1'b0;
      it.stamp    = stamp_clock;
      vertical    = 1'($urandom);
      thr = vertical ? int'(model_cfg.scroll_threshold) : int'(model_cfg.swipe_threshold);
      mag = thr + int'($urandom_range(0, 300)) - 100;
      if (mag < 0) mag = 0;
      if (mag > 32768) mag = 32768;
      other = ($urandom_range(7) == 0) ? mag : int'($urandom_range(0, mag));
      dval = ($urandom_range(1) == 0 || mag == 32768) ? -mag : mag;
      oval = ($urandom_range(1) == 0 || other == 32768) ? -other : other;
      if (vertical) begin
        it.delta_y = 16'(dval);
        it.delta_x = 16'(oval);
      end else begin
        it.delta_x = 16'(dval);
        it.delta_y = 16'(oval);
      end
    end else if (pick < 55) begin
      // touch with raw random fields
      it.mode = MODE_TOUCH;
    end else if (pick < 70) begin
      it.mode     = MODE_TOUCH;
      it.released = 1'b1;
      if ($urandom_range(1) == 0) begin
        travel = int'(model_cfg.tap_limit) + int'($urandom_range(0, 6)) - 3;
        it.moved_distance = 16'(travel);
      end
    end else begin
      it.mode = MODE_TICK;
    end
    return it;
  endfunction

  function automatic cfg_t rand_cfg();
    cfg_t c;
    c.scroll_threshold = 15'($urandom_range(0, 1500));
    c.swipe_threshold  = 15'($urandom_range(0, 1500));
    c.min_speed        = 15'($urandom_range(0, 200));
    c.max_speed        = 15'($urandom_range(0, 3000));
    c.decay_step       = 15'($urandom_range(0, 400));
    c.tap_limit        = 16'($urandom);
    c.scroll_interval  = ($urandom_range(3) == 0) ? RST_INTERVAL : 32'($urandom_range(0, 30));
    c.swipe_interval   = ($urandom_range(3) == 0) ? RST_INTERVAL : 32'($urandom_range(0, 30));
    return c;
  endfunction

  // offer an item and return at the edge of its transfer
  task automatic offer(input item_t it);
    touch_ch.valid          <= 1'b1;
    touch_ch.mode           <= it.mode;
    touch_ch.released       <= it.released;
    touch_ch.moved_distance <= it.moved_distance;
    touch_ch.pos_x          <= it.pos_x;
    touch_ch.pos_y          <= it.pos_y;
    touch_ch.delta_x        <= it.delta_x;
    touch_ch.delta_y        <= it.delta_y;
    touch_ch.stamp          <= it.stamp;
    @(posedge clk);
    while (!touch_ch.ready) @(posedge clk);
  endtask

  task automatic idle_gap();
    int gap;
    gap = 0;
    while ($urandom_range(99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      touch_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // wait for every expected result, then let in-flight items settle
  task automatic drain();
    while (expected_gestures.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // all registers, written back to back while idle
  task automatic load_cfg(input cfg_t c);
    logic [CFG_DATA_W-1:0] vals [8];
    vals[REG_SCROLL_THRESHOLD] = 32'(c.scroll_threshold);
    vals[REG_SWIPE_THRESHOLD]  = 32'(c.swipe_threshold);
    vals[REG_MIN_SPEED]        = 32'(c.min_speed);
    vals[REG_MAX_SPEED]        = 32'(c.max_speed);
    vals[REG_DECAY_STEP]       = 32'(c.decay_step);
    vals[REG_TAP_LIMIT]        = 32'(c.tap_limit);
    vals[REG_SCROLL_INTERVAL]  = c.scroll_interval;
    vals[REG_SWIPE_INTERVAL]   = c.swipe_interval;
    for (int i = 0; i < 8; i++) begin
      cfg_write <= 1'b1;
      cfg_index <= CFG_INDEX_W'(i);
      cfg_data  <= vals[i];
      @(posedge clk);
    end
    cfg_write <= 1'b0;
    model_cfg = c;
  endtask

  task automatic run_phase(input idle_mode_t mode, input int count, input int pause_at);
    item_t it;
    case (mode)
      IDLE_NONE: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
      IDLE_TX:   begin tx_idle_pct = 47; rx_stall_pct = 0;  end
      IDLE_RX:   begin tx_idle_pct = 0;  rx_stall_pct = 47; end
      default:   begin tx_idle_pct = 9;  rx_stall_pct = 9;  end
    endcase
    for (int k = 0; k < count; k++) begin
      if (k == pause_at) begin
        touch_ch.valid <= 1'b0;
        drain();
      end
      it = gen_item();
      offer(it);
      queue_prediction(it);
      idle_gap();
    end
    touch_ch.valid <= 1'b0;
    drain();
  endtask

  // ---------------------------------------------------------------- main

  initial begin
    result_t res [2];
    int      n;

    rst                     = 1'b1;
    cfg_write               = 1'b0;
    cfg_index               = '0;
    cfg_data                = '0;
    touch_ch.valid          = 1'b0;
    touch_ch.mode           = MODE_TOUCH;
    touch_ch.released       = 1'b0;
    touch_ch.moved_distance = '0;
    touch_ch.pos_x          = '0;
    touch_ch.pos_y          = '0;
    touch_ch.delta_x        = '0;
    touch_ch.delta_y        = '0;
    touch_ch.stamp          = '0;

    model_cfg = cfg_t'{RST_SCROLL_THRESHOLD, RST_SWIPE_THRESHOLD, RST_MIN_SPEED,
                       RST_MAX_SPEED, RST_DECAY_STEP, RST_TAP_LIMIT,
                       RST_INTERVAL, RST_INTERVAL};
    scroll_spd  = 0;
    swipe_spd   = 0;
    scroll_now  = '0;
    scroll_done = '0;
    swipe_now   = '0;
    swipe_done  = '0;

    // directed table, register defaults after reset
    // tick right after reset: speeds are zero, nothing released
    add_row(mk_item(MODE_TICK, 0, 0, 0, 0, 0, 0, 0), 1, 0, NO_RESULT, NO_RESULT);
    // lifts around the tap limit, position extremes
    add_row(mk_item(MODE_TOUCH, 1, 16'd0, 16'hFFFF, 16'h0000, 0, 0, 0), 1, 1,
            result_t'{KIND_TAP, 16'hFFFF, 16'h0000, 16'd0, 1'b1}, NO_RESULT);
    add_row(mk_item(MODE_TOUCH, 1, 16'd79, 16'h0000, 16'hFFFF, 0, 0, 0), 1, 1,
            result_t'{KIND_TAP, 16'h0000, 16'hFFFF, 16'd0, 1'b1}, NO_RESULT);
    add_row(mk_item(MODE_TOUCH, 1, 16'd80, 16'h1234, 16'h5678, 0, 0, 0), 1, 0,
            NO_RESULT, NO_RESULT);
    add_row(mk_item(MODE_TOUCH, 1, 16'hFFFF, 16'h1234, 16'h5678, 0, 0, 0), 1, 0,
            NO_RESULT, NO_RESULT);
    // moves: below threshold, at threshold, clamped
    add_row(mk_item(MODE_TOUCH, 0, 0, 0, 0, 16'sd0, 16'sd490, 32'd10), 1, 0,
            NO_RESULT, NO_RESULT);
    add_row(mk_item(MODE_TOUCH, 0, 0, 0, 0, 16'sd0, 16'sd491, 32'd20), 1, 0,
            NO_RESULT, NO_RESULT);
    add_row(mk_item(MODE_TOUCH, 0, 0, 0, 0, 16'sd0, 16'sd32767, 32'd25), 1, 0,
            NO_RESULT, NO_RESULT);
    add_row(mk_item(MODE_TICK, 0, 0, 0, 0, 0, 0, 0), 1, 1,
            result_t'{KIND_SCROLL_DOWN, 16'd0, 16'd0, 16'd491, 1'b1}, NO_RESULT);
    add_row(mk_item(MODE_TOUCH, 0, 0, 0, 0, 16'sh8000, 16'sd0, 32'd30), 1, 0,
            NO_RESULT, NO_RESULT);
    add_row(mk_item(MODE_TICK, 0, 0, 0, 0, 0, 0, 0), 1, 2,
            result_t'{KIND_SCROLL_DOWN, 16'd0, 16'd0, 16'd466, 1'b0},
            result_t'{KIND_SWIPE_LEFT, 16'd0, 16'd0, 16'd491, 1'b1});
    // tie of axes goes to swipe; vertical strictly larger goes to scroll
    add_row(mk_item(MODE_TOUCH, 0, 0, 0, 0, 16'sd600, -16'sd600, 32'd40), 0, 0,
            NO_RESULT, NO_RESULT);
    add_row(mk_item(MODE_TOUCH, 0, 0, 0, 0, 16'sd32767, 16'sh8000, 32'hFFFF_FFFF), 0, 0,
            NO_RESULT, NO_RESULT);
    // tick with junk in every other field
    add_row(mk_item(MODE_TICK, 1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'sh8000, 16'sh7FFF,
                    32'hFFFF_FFFF), 0, 0, NO_RESULT, NO_RESULT);
    // ticks until the swipe speed decays into the dead band
    for (int i = 0; i < 6; i++)
      add_row(mk_item(MODE_TICK, 0, 0, 0, 0, 0, 0, 0), 0, 0, NO_RESULT, NO_RESULT);
    // lift ignores its deltas
    add_row(mk_item(MODE_TOUCH, 1, 16'd100, 16'h00FF, 16'hFF00, 16'sh7FFF, 16'sh8000,
                    32'd50), 0, 0, NO_RESULT, NO_RESULT);
    add_row(mk_item(MODE_TOUCH, 0, 0, 0, 0, 16'sd490, -16'sd491, 32'd60), 0, 0,
            NO_RESULT, NO_RESULT);
    add_row(mk_item(MODE_TICK, 0, 0, 0, 0, 0, 0, 0), 0, 0, NO_RESULT, NO_RESULT);

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      offer(dir_rows[i].item);
      predict_gestures(dir_rows[i].item, res, n);
      if (dir_rows[i].fixed_exp) begin
        if (dir_rows[i].n > 0) enqueue_result(dir_rows[i].r0);
        if (dir_rows[i].n > 1) enqueue_result(dir_rows[i].r1);
      end else begin
        for (int k = 0; k < n; k++) enqueue_result(res[k]);
      end
    end
    touch_ch.valid <= 1'b0;
    drain();

    // random phases; the first starts with a long hold-off on results
    hold_left = 300;
    run_phase(IDLE_NONE, 190, -1);

    // zero thresholds, no dead band, no decay, every lift short of 16'hFFFF a tap
    load_cfg(cfg_t'{15'd0, 15'd0, 15'd0, 15'd32767, 15'd0, 16'hFFFF, 32'sd0, 32'sd0});
    run_phase(IDLE_TX, 190, -1);

    // clamp below the dead band, no taps
    load_cfg(cfg_t'{15'd100, 15'd100, 15'd300, 15'd100, 15'd32767, 16'd0,
                    32'sd3, 32'sd7});
    run_phase(IDLE_RX, 190, -1);

    // top thresholds and band, scroll never due; sender pauses midway
    load_cfg(cfg_t'{15'd32767, 15'd32767, 15'd32767, 15'd32767, 15'd1, 16'd1000,
                    32'sh7FFF_FFFF, RST_INTERVAL});
    run_phase(IDLE_BOTH, 190, 100);

    // decay larger than any speed: one release then zero
    load_cfg(cfg_t'{15'd200, 15'd300, 15'd5, 15'd2000, 15'd32767, 16'd400,
                    RST_INTERVAL, 32'sd20});
    run_phase(IDLE_NONE, 190, -1);

    load_cfg(rand_cfg());
    run_phase(IDLE_TX, 190, -1);
    load_cfg(rand_cfg());
    run_phase(IDLE_RX, 190, -1);

    load_cfg(cfg_t'{RST_SCROLL_THRESHOLD, RST_SWIPE_THRESHOLD, RST_MIN_SPEED,
                    RST_MAX_SPEED, RST_DECAY_STEP, RST_TAP_LIMIT,
                    RST_INTERVAL, 32'sd1});
    run_phase(IDLE_BOTH, 190, -1);

    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
